[src/gcl_pkg.sv]
// shared constants and types for the gcd / lcm unit
package gcl_pkg;

    // operand width actually used, low bits of each 32-bit port
    localparam int OW = 32;

    // width of the shift count for common factors of two
    localparam int KW = $clog2(OW);

    // width of the step counter for divide and multiply
    localparam int CW = $clog2(OW);
    localparam logic [CW-1:0] CNT_LAST = CW'(OW - 1);

    // operand of the shared adder and its result with carry out
    typedef logic [OW:0]   ext_t;
    typedef logic [OW+1:0] sum_t;

endpackage

[src/gcl_addsub.sv]
// shared adder / subtractor with carry out, used by the gcd subtract, divide and multiply steps
module gcl_addsub (
    input  gcl_pkg::ext_t op_a,
    input  gcl_pkg::ext_t op_b,
    input  logic          sub,
    output gcl_pkg::sum_t sum
);
    import gcl_pkg::*;

    ext_t op_b_inv;

    // invert the second operand for subtraction, carry in supplies the one
    assign op_b_inv = sub ? ~op_b : op_b;
    assign sum      = {1'b0, op_a} + {1'b0, op_b_inv} + (OW + 2)'(sub);

endmodule

[src/gcd_lcm_unit.sv]
// top level: sequencer and registers for gcd and lcm over one shared adder
//
//  channel   handshake              ports
//  -------   --------------------   ---------------------------------------
//  input     start && !busy         operand_a, operand_b
//  result    done (one-cycle pulse) gcd_value, lcm_value, zero_error
//
//  a zero operand gives its result in the cycle after start
//  otherwise binary gcd takes at most 2*OW-1 steps, then OW restoring divide
//  steps and OW shift-add multiply steps
//  the subtract, divide and multiply steps share the one adder
//  busy is high while a word is in work; results cannot be held off
//  reset clears the sequencer and the strobe at once
module gcd_lcm_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic        busy,
    output logic        done,
    output logic [31:0] gcd_value,
    output logic [63:0] lcm_value,
    output logic        zero_error
);
    import gcl_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_GCD  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_MUL  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [KW-1:0] k_reg, k_next;
    logic [OW-1:0] a_reg, a_next;
    logic [OW-1:0] b_reg, b_next;
    logic [OW-1:0] x_reg, x_next;
    logic [OW-1:0] y_reg, y_next;
    logic [OW-1:0] g_reg, g_next;
    logic          done_reg, done_next;
    logic [31:0]   gcd_out_reg, gcd_out_next;
    logic [63:0]   lcm_out_reg, lcm_out_next;
    logic          err_reg, err_next;

    logic [OW-1:0] a_in, b_in;
    logic          x_gt_y;
    logic          div_ge;
    ext_t          au_a, au_b;
    logic          au_sub;
    sum_t          au_sum;

    assign a_in   = operand_a[OW-1:0];
    assign b_in   = operand_b[OW-1:0];
    assign x_gt_y = x_reg > y_reg;
    assign div_ge = au_sum[OW+1];

    // operand select for the shared adder
    always_comb
    begin
        au_a   = '0;
        au_b   = '0;
        au_sub = 1'b0;
        case (state_reg)
            ST_GCD:
            begin
                au_sub = 1'b1;
                if (x_gt_y)
                begin
                    au_a = {1'b0, x_reg};
                    au_b = {1'b0, y_reg};
                end
                else
                begin
                    au_a = {1'b0, y_reg};
                    au_b = {1'b0, x_reg};
                end
            end
            ST_DIV:
            begin
                au_sub = 1'b1;
                au_a   = {x_reg, y_reg[OW-1]};
                au_b   = {1'b0, g_reg};
            end
            ST_MUL:
            begin
                au_a = {1'b0, x_reg};
                au_b = y_reg[0] ? {1'b0, b_reg} : '0;
            end
            default:
            begin
                au_sub = 1'b0;
            end
        endcase
    end

    gcl_addsub u_addsub (
        .op_a (au_a),
        .op_b (au_b),
        .sub  (au_sub),
        .sum  (au_sum)
    );

    // sequencer and datapath next values
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        g_next       = g_reg;
        done_next    = 1'b0;
        gcd_out_next = gcd_out_reg;
        lcm_out_next = lcm_out_reg;
        err_next     = err_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    a_next = a_in;
                    b_next = b_in;
                    x_next = a_in;
                    y_next = b_in;
                    k_next = '0;
                    if (a_in == '0 || b_in == '0)
                    begin
                        done_next    = 1'b1;
                        err_next     = 1'b1;
                        gcd_out_next = '0;
                        lcm_out_next = '0;
                    end
                    else
                    begin
                        state_next = ST_GCD;
                    end
                end
            end
            ST_GCD:
            begin
                if (x_reg == y_reg)
                begin
                    // gcd found, set up division of a by it
                    g_next     = x_reg << k_reg;
                    x_next     = '0;
                    y_next     = a_reg;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + KW'(1);
                end
                else if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (x_gt_y)
                begin
                    // difference of two odd values is even
                    x_next = {1'b0, au_sum[OW-1:1]};
                end
                else
                begin
                    y_next = {1'b0, au_sum[OW-1:1]};
                end
            end
            ST_DIV:
            begin
                // restoring divide, quotient shifts into y
                x_next   = div_ge ? au_sum[OW-1:0] : au_a[OW-1:0];
                y_next   = {y_reg[OW-2:0], div_ge};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    x_next     = '0;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // shift-add multiply of quotient by b, product in {x, y}
                x_next   = au_sum[OW:1];
                y_next   = {au_sum[0], y_reg[OW-1:1]};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next     = '0;
                    state_next   = ST_IDLE;
                    done_next    = 1'b1;
                    err_next     = 1'b0;
                    gcd_out_next = 32'(g_reg);
                    lcm_out_next = 64'({au_sum[OW:0], y_reg[OW-1:1]});
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        k_reg       <= k_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        g_reg       <= g_next;
        gcd_out_reg <= gcd_out_next;
        lcm_out_reg <= lcm_out_next;
        err_reg     <= err_next;
    end

    assign busy       = state_reg != ST_IDLE;
    assign done       = done_reg;
    assign gcd_value  = gcd_out_reg;
    assign lcm_value  = lcm_out_reg;
    assign zero_error = err_reg;

endmodule

[src/gcl_checker.sv]
// port-level checks for the gcd / lcm unit and their binding
module gcl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic [31:0] operand_a,
    input logic [31:0] operand_b,
    input logic        busy,
    input logic        done,
    input logic [31:0] gcd_value,
    input logic [63:0] lcm_value,
    input logic        zero_error
);

    // an accepted word either starts work or answers at once
    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted word neither started nor answered");

    // the end of work always delivers a result
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result strobe");

    // an error word carries zero results
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_error) |-> (gcd_value == 32'd0 && lcm_value == 64'd0))
        else $error("error word with nonzero results");

    // a valid word carries nonzero results with gcd not above lcm
    a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !zero_error) |->
            (gcd_value != 32'd0 && lcm_value >= {32'd0, gcd_value}))
        else $error("valid word with inconsistent results");

endmodule

bind gcd_lcm_unit gcl_checker u_gcl_checker (.*);

[test/tb.sv]
// testbench for gcd_lcm_unit: operand words, result prediction and field checks
`timescale 1ns / 100ps

// one expected result word
typedef struct {
    logic [31:0] gcd_value;
    logic [63:0] lcm_value;
    logic        zero_error;
} gcd_lcm_word_t;

// predicts gcd / lcm per accepted word and checks returned words in order
class divisor_scoreboard;
    gcd_lcm_word_t expected_results[$];
    int            failures;

    function new();
        failures = 0;
    endfunction

    // euclid on the masked operands, lcm at double width
    function gcd_lcm_word_t predict_gcd_lcm(logic [31:0] a_in, logic [31:0] b_in);
        gcd_lcm_word_t w;
        logic [63:0]   mask;
        logic [63:0]   x;
        logic [63:0]   y;
        logic [63:0]   r;
        logic [63:0]   a;
        logic [63:0]   b;
        mask = (64'd1 << gcl_pkg::OW) - 64'd1;
        a = {32'd0, a_in} & mask;
        b = {32'd0, b_in} & mask;
        if (a == 64'd0 || b == 64'd0)
        begin
            w.gcd_value  = 32'd0;
            w.lcm_value  = 64'd0;
            w.zero_error = 1'b1;
            return w;
        end
        x = a;
        y = b;
        while (y != 64'd0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        w.gcd_value  = x[31:0];
        w.lcm_value  = (a / x) * b;
        w.zero_error = 1'b0;
        return w;
    endfunction

    function void note_operands(logic [31:0] a, logic [31:0] b);
        expected_results.push_back(predict_gcd_lcm(a, b));
    endfunction

    function void check_result(logic [31:0] g, logic [63:0] l, logic z);
        gcd_lcm_word_t w;
        if (expected_results.size() == 0)
        begin
            $error("result word with no word pending: gcd %0d lcm %0d zero_error %0b",
                   g, l, z);
            failures++;
            return;
        end
        w = expected_results.pop_front();
        if (g !== w.gcd_value)
        begin
            $error("gcd_value: expected %0d, actual %0d", w.gcd_value, g);
            failures++;
        end
        if (l !== w.lcm_value)
        begin
            $error("lcm_value: expected %0d, actual %0d", w.lcm_value, l);
            failures++;
        end
        if (z !== w.zero_error)
        begin
            $error("zero_error: expected %0b, actual %0b", w.zero_error, z);
            failures++;
        end
    endfunction

    function int pending();
        return expected_results.size();
    endfunction
endclass

module tb;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic        busy;
    logic        done;
    logic [31:0] gcd_value;
    logic [63:0] lcm_value;
    logic        zero_error;

    divisor_scoreboard board;
    int                burst_left;

    gcd_lcm_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .busy      (busy),
        .done      (done),
        .gcd_value (gcd_value),
        .lcm_value (lcm_value),
        .zero_error(zero_error)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #25_000_000;
        $display("Verification failed");
        $finish;
    end

    // result monitor, samples the strobe at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(gcd_value, lcm_value, zero_error);
    end

    // idle cycles before the next word: mostly short, a few long, some bursts with none
    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 40)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // present one word at a falling edge, hold it until accepted; returns at a falling edge
    task automatic send_word(input logic [31:0] a, input logic [31:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start     <= 1'b0;
            operand_a <= $urandom;
            operand_b <= $urandom;
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        operand_a <= a;
        operand_b <= b;
        do
            @(posedge clk);
        while (busy);
        board.note_operands(a, b);
        @(negedge clk);
    endtask

    // hold off the sender until every pending word has returned
    task automatic drain_results();
        start <= 1'b0;
        do
            @(negedge clk);
        while (board.pending() != 0);
    endtask

    // random operand pair, weighted toward shared factors and divisibility
    task automatic pick_pair(output logic [31:0] a, output logic [31:0] b);
        int          kind;
        logic [31:0] g;
        kind = $urandom_range(0, 99);
        if (kind < 4)
        begin
            a = $urandom;
            b = $urandom;
            case ($urandom_range(0, 2))
                0: a = 32'd0;
                1: b = 32'd0;
                default:
                begin
                    a = 32'd0;
                    b = 32'd0;
                end
            endcase
        end
        else if (kind < 35)
        begin
            // common factor, products stay inside 32 bits
            g = ($urandom_range(0, 3) == 0) ? (32'd1 << $urandom_range(0, 15))
                                            : 32'($urandom_range(1, 65535));
            a = g * 32'($urandom_range(1, 65535));
            b = g * 32'($urandom_range(1, 65535));
        end
        else if (kind < 50)
        begin
            a = 32'($urandom_range(1, 300));
            b = 32'($urandom_range(1, 300));
        end
        else if (kind < 60)
        begin
            // one operand divides the other
            a = 32'($urandom_range(1, 65535));
            b = a * 32'($urandom_range(1, 65535));
            if ($urandom_range(0, 1) == 1)
            begin
                g = a;
                a = b;
                b = g;
            end
        end
        else if (kind < 70)
        begin
            a = $urandom << $urandom_range(0, 31);
            b = $urandom << $urandom_range(0, 31);
        end
        else
        begin
            a = $urandom;
            b = $urandom;
        end
    endtask

    // stimulus
    initial
    begin
        logic [31:0] a;
        logic [31:0] b;
        board      = new();
        burst_left = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        operand_a  = 32'd0;
        operand_b  = 32'd0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: zero operands, ones, extremes, primes, powers of two
        send_word(32'd0, 32'd0);
        send_word(32'd0, 32'd5);
        send_word(32'd7, 32'd0);
        send_word(32'd1000, 32'd0);
        send_word(32'd1, 32'd1);
        send_word(32'd1, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF, 32'd1);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_word(32'hFFFF_FFFB, 32'hFFFF_FFEF);
        send_word(32'h8000_0000, 32'h8000_0000);
        send_word(32'h8000_0000, 32'd1);
        send_word(32'h8000_0000, 32'hC000_0000);
        send_word(32'h8000_0000, 32'd3);
        send_word(32'hAAAA_AAAA, 32'h5555_5555);
        send_word(32'hF000_0000, 32'h0F00_0000);
        send_word(32'd12, 32'd18);
        send_word(32'd18, 32'd12);
        send_word(32'd2, 32'd3);
        send_word(32'd6, 32'd6);
        send_word(32'h1234_5678, 32'h1234_5678);
        drain_results();

        // random words with periodic drains
        for (int i = 0; i < 1800; i++)
        begin
            pick_pair(a, b);
            send_word(a, b);
            if (i % 450 == 449)
                drain_results();
        end

        // wait out the last words, then watch for stray strobes
        drain_results();
        repeat (140) @(posedge clk);
        if (board.failures == 0 && board.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
